// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the threshold encoder.
// Depends on nothing; SYNTH selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/tdce_pkg.sv
// Shared types, constants and the keep test of the threshold encoder.
// Used by the result queue, the top level, the checker and the testbench.
`default_nettype none
package tdce_pkg;
  localparam int unsigned COL_W = 16;
  localparam int unsigned OFS_W = 33;
  localparam int unsigned LEN_W = 17;
  localparam logic [LEN_W-1:0] FULL_LEN = 17'h10000;
  localparam logic [32:0] MAX_COLS = 33'h0_0001_0000;
  localparam logic [OFS_W-1:0] OFFSET_MAX = 33'h1_0000_0000;
  localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] EXP_ONES = 32'h7F80_0000;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {KIND_COL = 1'b0, KIND_OFS = 1'b1} kind_t;
  typedef enum logic {REG_THRESHOLD = 1'b0, REG_ROW_LENGTH = 1'b1} reg_idx_t;

  typedef struct packed {
    kind_t            kind;
    logic [COL_W-1:0] col_index;
    logic [OFS_W-1:0] row_offset;
    logic             last;
  } result_t;

  // Magnitude test on the raw IEEE patterns.
  function automatic logic keep_elem(input logic [31:0] v, input logic [31:0] thr);
    logic [31:0] mag;
    logic [31:0] tmag;
    mag  = v & ABS_MASK;
    tmag = thr & ABS_MASK;
    if (mag > EXP_ONES || tmag > EXP_ONES) return 1'b0;
    if (thr[31]) return 1'b1;
    return mag >= thr;
  endfunction
endpackage
`default_nettype wire

// File: hdl/tdce_queue.sv
// Small result queue that takes up to two results a cycle and emits one while out_stall is low.
// Depends on tdce_pkg for the result type.
`default_nettype none
`include "assert_macros.svh"
module tdce_queue #(
  parameter int unsigned DEPTH = tdce_pkg::QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire [1:0]              push_n,
  input  wire tdce_pkg::result_t push0,
  input  wire tdce_pkg::result_t push1,
  output logic                   room2,
  output logic                   out_valid,
  input  wire                    out_stall,
  output tdce_pkg::result_t      out_data
);
  import tdce_pkg::*;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            pop;
  logic [PW-1:0]   wr1;

  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_r];
  assign room2     = cnt_r <= CW'(DEPTH - 2);
  assign wr1       = wr_r + PW'(1);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= push0;
    if (push_n == 2'd2) mem_r[wr1] <= push1;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(push_n);
      rd_r  <= rd_r + PW'(pop);
      cnt_r <= cnt_r + CW'(push_n) - CW'(pop);
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "queue overfilled")
  `ASSERT_ALWAYS(a_push_room, clk, rst_n, push_n == 2'd0 || room2, "push without room")
  `ASSERT_NEXT(a_hold_head, clk, rst_n, out_valid && out_stall, out_valid, "stalled head lost")
endmodule
`default_nettype wire

// File: hdl/threshold_dense_to_csr_encoder.sv
// Top level of the threshold dense-to-CSR encoder.
// Depends on tdce_pkg, tdce_queue and assert_macros.svh.
//
// Usage: one float32 matrix element arrives per input beat (in_value_bits),
// row-major. Each element whose magnitude meets the threshold gives a column
// beat (kind 0). The last element of a row also gives an offset beat (kind 1)
// carrying the cumulative kept count, which saturates at 2^32. out_last marks
// the final beat caused by one element.
// Input path: an accepted beat is held in the input register and then enters
// a four-entry result queue, which drives the result port. The block accepts
// one element per cycle while in_stall is low; an element that gives two
// results needs two result beats, so a long run of such elements fills the
// queue and raises in_stall. Configuration (threshold, row length) is to be
// written over the APB port only while the block is idle; the block does not
// enforce this. Reset clears the column position, the kept count, the queue
// and the registers (threshold +0.0, row length 65536). When the receiver
// stalls, results wait in the queue; once fewer than two free entries remain, a held
// beat raises in_stall and stays in the input register.
`default_nettype none
`include "assert_macros.svh"
module threshold_dense_to_csr_encoder #(
  parameter int unsigned RESULT_DEPTH = tdce_pkg::QUEUE_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [31:0]                  in_value_bits,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_kind,
  output logic [tdce_pkg::COL_W-1:0]   out_col_index,
  output logic [tdce_pkg::OFS_W-1:0]   out_row_offset,
  output logic                         out_last,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [2:0]                   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tdce_pkg::*;

  // Configuration registers.
  logic [31:0]      thr_r;
  logic [LEN_W-1:0] len_r;
  reg_idx_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      len_r <= FULL_LEN;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        REG_THRESHOLD:  thr_r <= pwdata;
        REG_ROW_LENGTH: len_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_THRESHOLD:  prdata = thr_r;
      REG_ROW_LENGTH: prdata = {{(32-LEN_W){1'b0}}, len_r};
      default:        prdata = '0;
    endcase
  end

  // Input register.
  logic        vld_r;
  logic [31:0] val_r;
  logic        room2;
  logic        advance;

  assign in_stall = vld_r && !room2;
  assign advance  = vld_r && room2;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) val_r <= in_value_bits;
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= (in_valid && !in_stall) || (vld_r && !room2);
  end

  // Keep test, row end and counters.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [OFS_W-1:0] kept_r, kept_nxt;
  logic [LEN_W-1:0] eff_len;
  logic             kept, row_end;
  logic [LEN_W-1:0] col_p1;
  logic [1:0]       push_n;
  result_t          res_col, res_ofs, push0, push1;

  always_comb begin
    eff_len = len_r;
    if (len_r == '0 || len_r > FULL_LEN) eff_len = FULL_LEN;
    if ({{(33-LEN_W){1'b0}}, eff_len} > MAX_COLS) eff_len = MAX_COLS[LEN_W-1:0];
    kept    = keep_elem(val_r, thr_r);
    col_p1  = {1'b0, col_r} + LEN_W'(1);
    row_end = col_p1 >= eff_len;

    kept_nxt = kept_r;
    if (kept && kept_r < OFFSET_MAX) kept_nxt = kept_r + OFS_W'(1);
    col_nxt = row_end ? '0 : col_p1[COL_W-1:0];

    res_col = '{kind: KIND_COL, col_index: col_r, row_offset: '0, last: !row_end};
    res_ofs = '{kind: KIND_OFS, col_index: '0, row_offset: kept_nxt, last: 1'b1};
    push0   = kept ? res_col : res_ofs;
    push1   = res_ofs;
    push_n  = advance ? (2'(kept) + 2'(row_end)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      kept_r <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      kept_r <= kept_nxt;
    end
  end

  result_t q_out;

  tdce_queue #(.DEPTH(RESULT_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push0    (push0),
    .push1    (push1),
    .room2    (room2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (q_out)
  );

  assign out_kind       = q_out.kind;
  assign out_col_index  = q_out.col_index;
  assign out_row_offset = q_out.row_offset;
  assign out_last       = q_out.last;

  `ASSERT_ALWAYS(a_kept_sat, clk, rst_n, kept_r <= OFFSET_MAX, "kept count beyond saturation")
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall, vld_r && $stable(val_r), "input register lost a beat")
  `ASSERT_NEXT(a_row_wrap, clk, rst_n, advance && row_end, col_r == '0, "row end did not wrap column")
endmodule
`default_nettype wire

// File: dv/tdce_checker.sv
// Checker for the threshold dense-to-CSR encoder: watches the input, result and APB ports.
// It keeps its own copy of the registers and counters, predicts each result beat and compares.
// Depends on tdce_pkg.
`default_nettype none
module tdce_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  input  wire                           in_stall,
  input  wire  [31:0]                   in_value_bits,
  input  wire                           out_valid,
  input  wire                           out_stall,
  input  wire                           out_kind,
  input  wire  [tdce_pkg::COL_W-1:0]    out_col_index,
  input  wire  [tdce_pkg::OFS_W-1:0]    out_row_offset,
  input  wire                           out_last,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [2:0]                    paddr,
  input  wire  [31:0]                   pwdata,
  input  wire                           pready,
  output int                            fail_count,
  output int                            pending,
  output int                            elems_seen,
  output int                            beats_seen
);
  import tdce_pkg::*;

  logic [31:0]      thr_q;
  logic [LEN_W-1:0] len_q;
  logic [15:0]      col_pos;
  logic [32:0]      kept_cnt;
  result_t          csr_expected[$];

  assign pending = csr_expected.size();

  function automatic bit passes_threshold(input logic [31:0] v);
    logic [31:0] mag;
    mag = v & 32'h7FFF_FFFF;
    if (mag > 32'h7F80_0000) return 1'b0;
    if ((thr_q & 32'h7FFF_FFFF) > 32'h7F80_0000) return 1'b0;
    if (thr_q[31]) return 1'b1;
    return mag >= thr_q;
  endfunction

  // Works out the beats one element causes and advances the column and kept count.
  task automatic encode_element(input logic [31:0] v);
    int unsigned eff_len;
    bit          row_end;
    result_t     r;
    eff_len = (len_q == 0 || len_q > 17'h10000) ? 32'h10000 : 32'(len_q);
    row_end = (32'(col_pos) + 1) >= eff_len;
    if (passes_threshold(v)) begin
      if (kept_cnt < 33'h1_0000_0000) kept_cnt = kept_cnt + 33'd1;
      r.kind       = KIND_COL;
      r.col_index  = col_pos;
      r.row_offset = '0;
      r.last       = !row_end;
      csr_expected.push_back(r);
    end
    if (row_end) begin
      r.kind       = KIND_OFS;
      r.col_index  = '0;
      r.row_offset = kept_cnt;
      r.last       = 1'b1;
      csr_expected.push_back(r);
      col_pos = '0;
    end else begin
      col_pos = col_pos + 16'd1;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      thr_q    <= '0;
      len_q    <= FULL_LEN;
      col_pos   = '0;
      kept_cnt  = '0;
      csr_expected.delete();
      fail_count <= 0;
      elems_seen <= 0;
      beats_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_THRESHOLD) thr_q <= pwdata;
        else len_q <= pwdata[LEN_W-1:0];
      end
      if (out_valid && !out_stall) begin
        beats_seen <= beats_seen + 1;
        if (csr_expected.size() == 0) begin
          $error("result beat with nothing expected (kind %0d)", out_kind);
          fail_count <= fail_count + 1;
        end else begin
          e = csr_expected.pop_front();
          if (out_kind !== e.kind || out_col_index !== e.col_index ||
              out_row_offset !== e.row_offset || out_last !== e.last) begin
            fail_count <= fail_count + 1;
            if (out_kind !== e.kind)
              $error("kind: expected %0d, actual %0d", e.kind, out_kind);
            if (out_col_index !== e.col_index)
              $error("col_index: expected %0d, actual %0d", e.col_index, out_col_index);
            if (out_row_offset !== e.row_offset)
              $error("row_offset: expected %0d, actual %0d", e.row_offset, out_row_offset);
            if (out_last !== e.last)
              $error("last: expected %0d, actual %0d", e.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        elems_seen <= elems_seen + 1;
        encode_element(in_value_bits);
      end
    end
  end
endmodule
`default_nettype wire

// File: dv/tb.sv
// Top of the testbench for the threshold dense-to-CSR encoder: clock, reset, stimulus, verdict.
// Depends on tdce_pkg, the encoder RTL and tdce_checker, which checks every result beat.
`default_nettype none
module tb;
  import tdce_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [31:0]         in_value_bits;
  logic                out_valid;
  logic                out_stall;
  logic                out_kind;
  logic [COL_W-1:0]    out_col_index;
  logic [OFS_W-1:0]    out_row_offset;
  logic                out_last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int fail_count;
  int pending;
  int elems_seen;
  int beats_seen;

  // Idle probabilities in percent for the current phase; the receiver side is
  // handled by its own always block so stalls fall on any cycle.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [31:0] cur_thr;

  threshold_dense_to_csr_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value_bits(in_value_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_col_index(out_col_index), .out_row_offset(out_row_offset), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tdce_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value_bits(in_value_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_col_index(out_col_index), .out_row_offset(out_row_offset), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending),
    .elems_seen(elems_seen), .beats_seen(beats_seen)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver decides each cycle whether to stall, independently of out_valid.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Runaway guard, far above the slowest legal run.
  initial begin
    #(12 * 600000);
    $display("FAIL");
    $finish;
  end

  // One element beat. The idle decision comes before valid is raised so that
  // valid gets a single assignment at each edge.
  task automatic send_element(input logic [31:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value_bits <= $urandom;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_bits <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data at
  // the edge that ends the access cycle.
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait for every expected beat, then let the pipeline
  // settle, since a dropped element can still be in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_phase(input logic [31:0] thr, input logic [LEN_W-1:0] len,
                           input int unsigned idle_pct, input int unsigned stall_pct);
    drain_results();
    apb_write(REG_THRESHOLD, thr);
    apb_write(REG_ROW_LENGTH, 32'(len));
    cur_thr        = thr;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Element values: plain random patterns, values right around the threshold
  // magnitude with either sign, infinities, NaNs, zeros, subnormals and normals of moderate exponent.
  function automatic logic [31:0] pick_value();
    logic [31:0] base;
    case ($urandom_range(9))
      0, 1, 2, 3: pick_value = $urandom;
      4, 5, 6: begin
        base = cur_thr & ABS_MASK;
        base = base + $urandom_range(4) - 2;
        pick_value = {1'($urandom_range(1)), base[30:0]};
      end
      7: begin
        case ($urandom_range(5))
          0: pick_value = 32'h7F80_0000;
          1: pick_value = 32'hFF80_0000;
          2: pick_value = 32'h7FC0_0000 | $urandom_range(255);
          3: pick_value = 32'hFFFF_FFFF;
          4: pick_value = 32'h7F80_0001;
          default: pick_value = 32'h8000_0000;
        endcase
      end
      8: pick_value = {1'($urandom_range(1)), 8'($urandom_range(110, 140)), 23'($urandom)};
      default: pick_value = {1'($urandom_range(1)), 8'h00, 23'($urandom_range(3))};
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_element(pick_value());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value_bits = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_thr        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: threshold 1.0 and five columns; exact ties, just below and
    // above, both zeros, both infinities and NaNs of either sign.
    set_phase(32'h3F80_0000, 17'd5, 0, 0);
    send_element(32'h3F80_0000);
    send_element(32'hBF80_0000);
    send_element(32'h3F7F_FFFF);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7F80_0000);
    send_element(32'hFF80_0000);
    send_element(32'h7FC0_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h3F80_0001);
    // A NaN threshold keeps nothing, yet rows still end with an offset.
    set_phase(32'h7FC0_0001, 17'd2, 0, 0);
    send_element(32'h7F80_0000);
    send_element(32'h3F80_0000);
    send_element(32'h0000_0000);
    // A minus-zero threshold keeps every non-NaN element, zero included.
    set_phase(32'h8000_0000, 17'd3, 0, 0);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7F80_0001);
    // A negative threshold behaves the same; single-column rows end at once.
    set_phase(32'hC000_0000, 17'd1, 0, 0);
    send_element(32'h0000_0001);
    send_element(32'hFF80_0000);
    // Row length zero counts as full length; an infinite threshold keeps only infinities.
    set_phase(32'h7F80_0000, 17'd0, 0, 0);
    send_element(32'h7F80_0000);
    send_element(32'h7F7F_FFFF);
    // Shrinking the row while the column is past the new end closes the row.
    set_phase(32'h7F80_0000, 17'd1, 0, 0);
    send_element(32'hFF80_0000);

    // Random phases walk through the idle modes, threshold extremes and row
    // lengths, including the maximum and a value beyond it.
    set_phase(32'h3F80_0000, 17'd7, 0, 0);
    random_phase(240);
    set_phase(32'h0000_0000, 17'd3, 86, 0);
    random_phase(200);
    set_phase(32'h4120_0000, 17'd16, 0, 86);
    random_phase(240);
    set_phase(32'hFFFF_FFFF, 17'd2, 20, 20);
    random_phase(150);
    set_phase(32'h7F7F_FFFF, 17'h1FFFF, 0, 0);
    random_phase(120);
    set_phase(32'hBF80_0000, 17'd1, 86, 0);
    random_phase(150);
    set_phase($urandom, 17'($urandom_range(1, 40)), 20, 20);
    random_phase(240);
    set_phase(32'h3E80_0000, 17'h10000, 0, 86);
    random_phase(120);
    set_phase(32'h7F80_0000, 17'd5, 0, 0);
    random_phase(100);
    set_phase(32'h0080_0000, 17'($urandom_range(1, 40)), 20, 20);
    random_phase(250);

    // Wait for the tail, with a bound, then settle past the pipeline latency.
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d elements and %0d result beats across thresholds,", elems_seen,
             beats_seen);
    $display("row lengths and idle/stall mixes; %0d mismatches.", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: threshold_dense_to_csr_encoder.f
+incdir+hdl
hdl/tdce_pkg.sv
hdl/tdce_queue.sv
hdl/threshold_dense_to_csr_encoder.sv
dv/tdce_checker.sv
dv/tb.sv
